/* sv/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property with asynchronous reset disable
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent in one cycle, consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/pca_pkg.sv */
// ----------------------------------------------------------------------------
// pca_pkg
// types, constants and tables of the peak compressor
// ----------------------------------------------------------------------------
package pca_pkg;

	localparam int CHANNELS_DEF       = 2;
	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int LOG_TABLE_BITS_DEF = 6;

	// configuration register indexes
	localparam logic [2:0] REG_ENABLED   = 3'd0;
	localparam logic [2:0] REG_THRESHOLD = 3'd1;
	localparam logic [2:0] REG_SCENE     = 3'd2;
	localparam logic [2:0] REG_SLOPE     = 3'd3;
	localparam logic [2:0] REG_MAKEUP    = 3'd4;
	localparam logic [2:0] REG_ATTACK    = 3'd5;
	localparam logic [2:0] REG_SUSTAIN   = 3'd6;
	localparam logic [2:0] REG_TRANSIENT = 3'd7;

	localparam logic [15:0] THRESHOLD_RST = 16'hEE00;
	localparam logic [15:0] SCENE_RST     = 16'h9800;
	localparam logic [16:0] SLOPE_RST     = 17'h18000;
	localparam logic [15:0] ATTACK_RST    = 16'd655;
	localparam logic [15:0] SUSTAIN_RST   = 16'd34;
	localparam logic [15:0] TRANSIENT_RST = 16'd136;

	localparam logic [24:0] PEAK_COEF   = 25'd273;
	localparam logic [24:0] RMS_COEF    = 25'd27;
	localparam logic [24:0] CREST_COEF  = 25'd14;
	localparam logic [24:0] DB_PER_LOG2 = 25'd394566;
	localparam logic [24:0] LOG2_PER_DB = 25'd2786619;

	localparam logic signed [16:0] CREST_ENTER = 17'sd1536;
	localparam logic signed [16:0] CREST_EXIT  = 17'sd768;
	localparam logic signed [16:0] THR_CEIL    = -17'sd256;
	localparam logic signed [16:0] FLOOR_DB    = -17'sd25600;

	localparam int FRAC_BITS = 22;

	localparam logic [17:0] EXP_TAB [17] = '{
		18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
		18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
		18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
	};

	// request to the shared multiply and round unit
	typedef struct packed {
		logic               go;
		logic signed [33:0] a;
		logic signed [24:0] b;
		logic [5:0]         sh;
		logic               rnd;
	} mul_req_t;

	// log2(1 + k / 2^bits) in q16 by repeated squaring, elaboration only
	function automatic int unsigned log_entry(input int k, input int bits);
		longint unsigned y;
		int unsigned     r;
		r = 0;
		if (k >= (1 << bits)) begin
			return 65536;
		end
		y = longint'((1 << bits) + k) << (30 - bits);
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 30;
			r = r << 1;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				r = r | 1;
			end
		end
		return r;
	endfunction

endpackage

/* sv/pca_mul.sv */
// ----------------------------------------------------------------------------
// pca_mul
// shared signed multiplier with registered product and rounding shift
// ----------------------------------------------------------------------------
module pca_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  pca_pkg::mul_req_t   req,
	output logic signed [58:0]  res
);

	logic [33:0] mag_a;
	logic [24:0] mag_b;
	logic [57:0] prod_q;
	logic        neg_q;
	logic [5:0]  sh_q;
	logic        rnd_q;
	logic [58:0] rounded;
	logic [58:0] shifted;

	assign mag_a = req.a[33] ? 34'(-req.a) : 34'(req.a);
	assign mag_b = req.b[24] ? 25'(-req.b) : 25'(req.b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q  <= '0;
			rnd_q <= 1'b0;
			neg_q <= 1'b0;
		end else if (req.go) begin
			sh_q  <= req.sh;
			rnd_q <= req.rnd;
			neg_q <= req.a[33] ^ req.b[24];
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			prod_q <= 58'(mag_a * mag_b);
		end
	end

	always_comb begin
		rounded = {1'b0, prod_q};
		if (rnd_q && sh_q != 6'd0) begin
			rounded = rounded + (59'd1 << (sh_q - 6'd1));
		end
		shifted = rounded >> sh_q;
		res     = neg_q ? -$signed(shifted) : $signed(shifted);
	end

endmodule

/* sv/pca_gain.sv */
// ----------------------------------------------------------------------------
// pca_gain
// scales a linear gain product by the power of two and saturates
// ----------------------------------------------------------------------------
module pca_gain #(
	parameter int SAMPLE_BITS = pca_pkg::SAMPLE_BITS_DEF
) (
	input  logic [57:0]                   mag,
	input  logic signed [5:0]             expn,
	input  logic                          neg,
	output logic signed [SAMPLE_BITS-1:0] sample
);

	logic signed [6:0] sh;
	logic [63:0]       m;
	logic [63:0]       lim;

	always_comb begin
		sh  = 7'sd16 - 7'(expn);
		m   = {6'b0, mag};
		lim = (64'd1 << (SAMPLE_BITS - 1)) - (neg ? 64'd0 : 64'd1);
		if (sh > 7'sd0) begin
			m = (m + (64'd1 << (sh - 7'sd1))) >> sh;
		end else begin
			m = m << (-sh);
		end
		if (m > lim) begin
			m = lim;
		end
		sample = neg ? -$signed(SAMPLE_BITS'(m)) : $signed(SAMPLE_BITS'(m));
	end

endmodule

/* sv/peak_compressor_adaptive_release.sv */
// ----------------------------------------------------------------------------
// peak_compressor_adaptive_release
// stereo peak compressor with crest driven release selection
// ----------------------------------------------------------------------------
// one stereo frame enters on the s_ group, one gained frame leaves on the
// m_ group. s_tready is high only while the sequencer is idle.
// the sequencer drives one shared multiplier through its steps: three
// follower updates, three level to db conversions (five normalize steps,
// an interpolation and a scale each), crest smoothing, gain, exp2 and two
// sample scalings. a compressing word runs all of these steps before
// m_tvalid; a pass-through word (enabled clear) skips them.
// the sequencer holds its last step while m_tvalid waits for m_tready,
// so a stalled receiver stops further words at the input.
// configuration writes on cfg_we take effect at once and are meant to be
// made while idle.
// reset clears the followers, the crest average and the release mode and
// loads the default register values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module peak_compressor_adaptive_release #(
	parameter int CHANNELS       = pca_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS    = pca_pkg::SAMPLE_BITS_DEF,
	parameter int LOG_TABLE_BITS = pca_pkg::LOG_TABLE_BITS_DEF,
	localparam int DW            = ((2 * SAMPLE_BITS + 16 + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [DW-1:0] s_tdata,   // sample_left, sample_right, scene_stream_db
	input  logic [0:0]    s_tuser,   // scene_stream_present
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [DW-1:0] m_tdata,   // out_left, out_right, applied_gain_db
	output logic [0:0]    m_tuser,   // transient_active
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [16:0]   cfg_data
);

	localparam int SB    = SAMPLE_BITS;
	localparam int LB    = SB - 1;
	localparam int TAB_N = 1 << LOG_TABLE_BITS;
	localparam int RB    = pca_pkg::FRAC_BITS - LOG_TABLE_BITS;
	localparam logic [LB-1:0] MAXMAG = {LB{1'b1}};
	localparam longint FLOOR_RAW = ((64'd1 << (SB - 1)) + 64'd500000) / 64'd1000000;
	localparam logic [LB-1:0] FLOOR_LVL = (FLOOR_RAW < 1) ? LB'(1) : LB'(FLOOR_RAW);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_PEAK = 5'd1;
	localparam logic [4:0] ST_ENV  = 5'd2;
	localparam logic [4:0] ST_PKF  = 5'd3;
	localparam logic [4:0] ST_RMS  = 5'd4;
	localparam logic [4:0] ST_RMSW = 5'd5;
	localparam logic [4:0] ST_NORM = 5'd6;
	localparam logic [4:0] ST_INTP = 5'd7;
	localparam logic [4:0] ST_LGS  = 5'd8;
	localparam logic [4:0] ST_DBR  = 5'd9;
	localparam logic [4:0] ST_CAVG = 5'd10;
	localparam logic [4:0] ST_THR  = 5'd11;
	localparam logic [4:0] ST_GAIN = 5'd12;
	localparam logic [4:0] ST_EXPF = 5'd13;
	localparam logic [4:0] ST_EXPI = 5'd14;
	localparam logic [4:0] ST_MULR = 5'd15;
	localparam logic [4:0] ST_FIN  = 5'd16;
	localparam logic [4:0] ST_PASS = 5'd17;

	localparam logic [1:0] DB_PEAK = 2'd0;
	localparam logic [1:0] DB_RMS  = 2'd1;
	localparam logic [1:0] DB_ENV  = 2'd2;

	logic [4:0] state_q;

	logic                 en_q;
	logic signed [15:0]   thr_q;
	logic signed [15:0]   base_q;
	logic signed [16:0]   slope_q;
	logic signed [15:0]   makeup_q;
	logic [15:0]          attack_q;
	logic [15:0]          sustain_q;
	logic [15:0]          transient_q;

	logic signed [SB-1:0] l_q;
	logic signed [SB-1:0] r_q;
	logic signed [15:0]   scene_q;
	logic                 pres_q;

	logic [LB-1:0]        env_q;
	logic [LB-1:0]        pf_q;
	logic [LB-1:0]        rms_q;
	logic signed [15:0]   crest_q;
	logic                 mode_q;
	logic [LB-1:0]        peak_q;

	logic [31:0]          nv_q;
	logic [4:0]           np_q;
	logic [2:0]           nstep_q;
	logic [1:0]           dbsel_q;
	logic                 zero_q;
	logic [16:0]          t0_q;
	logic signed [16:0]   dbpf_q;
	logic signed [16:0]   envdb_q;
	logic signed [15:0]   applied_q;
	logic signed [5:0]    n_q;
	logic [17:0]          ebase_q;
	logic [17:0]          m_q;
	logic signed [SB-1:0] gl_q;

	logic signed [SB-1:0] ol_q;
	logic signed [SB-1:0] or_q;
	logic signed [15:0]   og_q;
	logic                 ot_q;
	logic                 mvalid_q;

	logic [16:0]          log_tab [TAB_N+1];

	pca_pkg::mul_req_t    req;
	logic signed [58:0]   res;
	logic signed [SB-1:0] gained;
	logic                 gain_neg;

	logic                 s_acc;
	logic                 out_free;
	logic [SB:0]          ml;
	logic [SB:0]          mr;
	logic [SB:0]          pk;
	logic [LB-1:0]        peak;
	logic [LB-1:0]        rl;
	logic [4:0]           shamt;
	logic [LOG_TABLE_BITS:0] ki;
	logic [RB-1:0]        rr;
	logic signed [7:0]    pe;
	logic signed [24:0]   lg;
	logic signed [16:0]   dbr;
	logic signed [16:0]   db;
	logic signed [16:0]   crest;
	logic signed [15:0]   cavg;
	logic signed [16:0]   sthr;
	logic signed [16:0]   thr;
	logic signed [24:0]   gr;
	logic signed [15:0]   applied;
	logic [4:0]           ek;
	logic [17:0]          m_now;
	logic [15:0]          rel_coef;

	for (genvar g = 0; g <= TAB_N; g++) begin : g_log
		assign log_tab[g] = 17'(pca_pkg::log_entry(g, LOG_TABLE_BITS));
	end

	pca_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	pca_gain #(
		.SAMPLE_BITS (SB)
	) u_gain (
		.mag    (res[57:0]),
		.expn   (n_q),
		.neg    (gain_neg),
		.sample (gained)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !mvalid_q || m_tready;
	assign gain_neg = (state_q == ST_MULR) ? l_q[SB-1] : r_q[SB-1];

	always_comb begin
		ml   = l_q[SB-1] ? (SB+1)'(-$signed({l_q[SB-1], l_q})) : (SB+1)'({1'b0, l_q});
		mr   = '0;
		if (CHANNELS > 1) begin
			mr = r_q[SB-1] ? (SB+1)'(-$signed({r_q[SB-1], r_q})) : (SB+1)'({1'b0, r_q});
		end
		pk   = (ml > mr) ? ml : mr;
		peak = (pk > (SB+1)'(MAXMAG)) ? MAXMAG : pk[LB-1:0];
		rl   = (rms_q > FLOOR_LVL) ? rms_q : FLOOR_LVL;

		case (nstep_q)
			3'd0:    shamt = 5'd16;
			3'd1:    shamt = 5'd8;
			3'd2:    shamt = 5'd4;
			3'd3:    shamt = 5'd2;
			default: shamt = 5'd1;
		endcase

		ki = {1'b0, nv_q[30 -: LOG_TABLE_BITS]};
		rr = nv_q[30-LOG_TABLE_BITS -: RB];
		pe = $signed({3'b0, np_q}) - 8'(SB - 1);
		lg = $signed({8'b0, t0_q}) + $signed(res[24:0]) + $signed({pe[7], pe, 16'b0});
		dbr = res[16:0];
		db  = (zero_q || dbr < pca_pkg::FLOOR_DB) ? pca_pkg::FLOOR_DB : dbr;
		crest = dbpf_q - db;
		cavg  = crest_q + res[15:0];

		sthr = 17'(scene_q) + 17'(base_q);
		if (sthr > pca_pkg::THR_CEIL) begin
			sthr = pca_pkg::THR_CEIL;
		end
		thr = pres_q ? sthr : 17'(thr_q);

		gr = $signed(res[24:0]) + 25'(makeup_q);
		if (gr > 25'sd32767) begin
			applied = 16'sd32767;
		end else if (gr < -25'sd32768) begin
			applied = -16'sd32768;
		end else begin
			applied = gr[15:0];
		end

		ek       = {1'b0, res[15:12]};
		m_now    = ebase_q + res[17:0];
		rel_coef = mode_q ? transient_q : sustain_q;
	end

	always_comb begin
		req     = '0;
		req.rnd = 1'b1;
		req.sh  = 6'd16;
		case (state_q)
			ST_ENV: begin
				req.go = 1'b1;
				req.a  = $signed({{(34-LB){1'b0}}, peak_q}) - $signed({{(34-LB){1'b0}}, env_q});
				req.b  = $signed({9'b0, (peak_q > env_q) ? attack_q : rel_coef});
			end
			ST_PKF: begin
				req.go = 1'b1;
				req.a  = $signed({{(34-LB){1'b0}}, peak_q}) - $signed({{(34-LB){1'b0}}, pf_q});
				req.b  = pca_pkg::PEAK_COEF;
			end
			ST_RMS: begin
				req.go = 1'b1;
				req.a  = $signed({{(34-LB){1'b0}}, peak_q}) - $signed({{(34-LB){1'b0}}, rms_q});
				req.b  = pca_pkg::RMS_COEF;
			end
			ST_INTP: begin
				req.go  = 1'b1;
				req.a   = 34'(log_tab[ki + 1'b1]) - 34'(log_tab[ki]);
				req.b   = 25'(rr);
				req.sh  = 6'(RB);
				req.rnd = 1'b0;
			end
			ST_LGS: begin
				req.go = 1'b1;
				req.a  = 34'(lg);
				req.b  = pca_pkg::DB_PER_LOG2;
				req.sh = 6'd24;
			end
			ST_DBR: begin
				req.go = (dbsel_q == DB_RMS);
				req.a  = 34'(crest) - 34'(crest_q);
				req.b  = pca_pkg::CREST_COEF;
			end
			ST_THR: begin
				req.go = 1'b1;
				req.a  = (envdb_q > thr) ? 34'(envdb_q) - 34'(thr) : 34'sd0;
				req.b  = 25'(slope_q);
			end
			ST_GAIN: begin
				req.go = 1'b1;
				req.a  = 34'(applied);
				req.b  = pca_pkg::LOG2_PER_DB;
			end
			ST_EXPF: begin
				req.go = 1'b1;
				req.a  = 34'(pca_pkg::EXP_TAB[ek + 5'd1]) - 34'(pca_pkg::EXP_TAB[ek]);
				req.b  = 25'(res[11:0]);
				req.sh = 6'd12;
			end
			ST_EXPI: begin
				req.go  = 1'b1;
				req.a   = 34'(ml);
				req.b   = 25'(m_now);
				req.sh  = 6'd0;
				req.rnd = 1'b0;
			end
			ST_MULR: begin
				req.go  = 1'b1;
				req.a   = 34'(mr);
				req.b   = 25'(m_q);
				req.sh  = 6'd0;
				req.rnd = 1'b0;
			end
			default: begin
				req.go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= 1'b1;
			thr_q       <= pca_pkg::THRESHOLD_RST;
			base_q      <= pca_pkg::SCENE_RST;
			slope_q     <= pca_pkg::SLOPE_RST;
			makeup_q    <= '0;
			attack_q    <= pca_pkg::ATTACK_RST;
			sustain_q   <= pca_pkg::SUSTAIN_RST;
			transient_q <= pca_pkg::TRANSIENT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pca_pkg::REG_ENABLED:   en_q        <= cfg_data[0];
				pca_pkg::REG_THRESHOLD: thr_q       <= cfg_data[15:0];
				pca_pkg::REG_SCENE:     base_q      <= cfg_data[15:0];
				pca_pkg::REG_SLOPE:     slope_q     <= cfg_data;
				pca_pkg::REG_MAKEUP:    makeup_q    <= cfg_data[15:0];
				pca_pkg::REG_ATTACK:    attack_q    <= cfg_data[15:0];
				pca_pkg::REG_SUSTAIN:   sustain_q   <= cfg_data[15:0];
				pca_pkg::REG_TRANSIENT: transient_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			env_q    <= '0;
			pf_q     <= '0;
			rms_q    <= '0;
			crest_q  <= '0;
			mode_q   <= 1'b0;
			mvalid_q <= 1'b0;
			nstep_q  <= '0;
			dbsel_q  <= DB_PEAK;
		end else begin
			if (mvalid_q && m_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_PEAK;
					end
				end
				ST_PEAK: state_q <= en_q ? ST_ENV : ST_PASS;
				ST_ENV:  state_q <= ST_PKF;
				ST_PKF: begin
					env_q   <= LB'(env_q + LB'(res));
					state_q <= ST_RMS;
				end
				ST_RMS: begin
					pf_q    <= LB'(pf_q + LB'(res));
					state_q <= ST_RMSW;
				end
				ST_RMSW: begin
					rms_q   <= LB'(rms_q + LB'(res));
					dbsel_q <= DB_PEAK;
					nstep_q <= '0;
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					nstep_q <= nstep_q + 3'd1;
					if (nstep_q == 3'd4) begin
						state_q <= ST_INTP;
					end
				end
				ST_INTP: state_q <= ST_LGS;
				ST_LGS:  state_q <= ST_DBR;
				ST_DBR: begin
					nstep_q <= '0;
					case (dbsel_q)
						DB_PEAK: begin
							dbsel_q <= DB_RMS;
							state_q <= ST_NORM;
						end
						DB_RMS:  state_q <= ST_CAVG;
						default: state_q <= ST_THR;
					endcase
				end
				ST_CAVG: begin
					crest_q <= cavg;
					if (!mode_q && 17'(cavg) > pca_pkg::CREST_ENTER) begin
						mode_q <= 1'b1;
					end else if (mode_q && 17'(cavg) < pca_pkg::CREST_EXIT) begin
						mode_q <= 1'b0;
					end
					dbsel_q <= DB_ENV;
					nstep_q <= '0;
					state_q <= ST_NORM;
				end
				ST_THR:  state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_EXPF;
				ST_EXPF: state_q <= ST_EXPI;
				ST_EXPI: state_q <= ST_MULR;
				ST_MULR: state_q <= ST_FIN;
				ST_FIN, ST_PASS: begin
					if (out_free) begin
						mvalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			l_q     <= s_tdata[SB-1:0];
			r_q     <= s_tdata[2*SB-1:SB];
			scene_q <= s_tdata[2*SB+15:2*SB];
			pres_q  <= s_tuser[0];
		end
		case (state_q)
			ST_PEAK: peak_q <= peak;
			ST_RMSW: begin
				nv_q   <= 32'(pf_q);
				zero_q <= (pf_q == '0);
				np_q   <= 5'd31;
			end
			ST_NORM: begin
				if ((nv_q >> (6'd32 - 6'(shamt))) == 32'd0) begin
					nv_q <= nv_q << shamt;
					np_q <= np_q - shamt;
				end
			end
			ST_INTP: t0_q <= log_tab[ki];
			ST_DBR: begin
				case (dbsel_q)
					DB_PEAK: begin
						dbpf_q <= db;
						nv_q   <= 32'(rl);
						zero_q <= 1'b0;
						np_q   <= 5'd31;
					end
					DB_RMS:  ;
					default: envdb_q <= db;
				endcase
			end
			ST_CAVG: begin
				nv_q   <= 32'(env_q);
				zero_q <= (env_q == '0);
				np_q   <= 5'd31;
			end
			ST_GAIN: applied_q <= applied;
			ST_EXPF: begin
				n_q     <= res[21:16];
				ebase_q <= pca_pkg::EXP_TAB[ek];
			end
			ST_EXPI: m_q <= m_now;
			ST_MULR: gl_q <= gained;
			ST_FIN: begin
				if (out_free) begin
					ol_q <= gl_q;
					or_q <= (CHANNELS > 1) ? gained : '0;
					og_q <= applied_q;
					ot_q <= mode_q;
				end
			end
			ST_PASS: begin
				if (out_free) begin
					ol_q <= l_q;
					or_q <= (CHANNELS > 1) ? r_q : '0;
					og_q <= '0;
					ot_q <= mode_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = DW'({og_q, or_q, ol_q});
	assign m_tuser  = ot_q;

endmodule

/* sv/pca_chk.sv */
// ----------------------------------------------------------------------------
// pca_chk
// port level checks of the peak compressor, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pca_chk #(
	parameter int DW = 64
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [DW-1:0] m_tdata
);

	// one word in flight: input closes after each accept
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// a result appears only from a busy sequencer
	`ASSERT_CLK(a_result_from_busy, clk, arst_n, $rose(m_tvalid) |-> $past(!s_tready))

	// stalled result stays put
	`ASSERT_NEXT(a_hold_stall, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind peak_compressor_adaptive_release pca_chk #(
	.DW (DW)
) u_pca_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* bench/peak_compressor_adaptive_release_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peak_compressor_adaptive_release_test
// self-checking bench of the stereo peak compressor
// ----------------------------------------------------------------------------
// an in-bench gain predictor tracks the envelope, the followers, the crest
// average and the release mode, and computes each gained frame. frames are
// sent through one task with random gaps, and a checker process compares
// every output word against the oldest predicted frame. test tasks cover
// defaults, extremes, pass-through, scene thresholds, slopes and
// coefficients, then a long random run ends with gaps and stalls off.
// ----------------------------------------------------------------------------
module peak_compressor_adaptive_release_test;

	localparam int SB = 24;
	localparam int DW = 64;
	localparam int LTB = 6;
	localparam int WATCH_LIMIT = 20000;

	typedef struct {
		logic [23:0] left;
		logic [23:0] right;
		logic [15:0] gain_db;
		logic        transient;
	} frame_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [DW-1:0] s_tdata;
	logic [0:0]    s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	logic [DW-1:0] m_tdata;
	logic [0:0]    m_tuser;
	logic          cfg_we;
	logic [2:0]    cfg_index;
	logic [16:0]   cfg_data;

	frame_t        frames_due[$];
	int            fail_count;
	int            idle_cycles;
	bit            gaps_on;

	// predictor copy of registers and state
	bit            p_enabled;
	longint        p_thr, p_scene, p_slope, p_makeup;
	longint        p_attack, p_sustain, p_transient;
	longint        p_env, p_peak, p_rms, p_crest;
	bit            p_fast;
	longint        exp_lut[17];

	peak_compressor_adaptive_release u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint mul_rnd(longint a, longint b, int sh);
		longint ma, mb, p;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = (ma * mb + (longint'(1) << (sh - 1))) >>> sh;
		return ((a < 0) != (b < 0)) ? -p : p;
	endfunction

	function automatic longint track(longint cur, longint target, longint coef);
		return cur + mul_rnd(target - cur, coef, 16);
	endfunction

	function automatic longint log_q16(longint k);
		longint unsigned y;
		longint r;
		r = 0;
		if (k >= (1 << LTB)) begin
			return 65536;
		end
		y = longint'((1 << LTB) + k) << (30 - LTB);
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 30;
			r = r << 1;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				r = r | 1;
			end
		end
		return r;
	endfunction

	function automatic longint level_db(longint v);
		int p;
		longint f, k, r, t0, t1, lg, db;
		if (v == 0) begin
			return -25600;
		end
		p = 31;
		while (((v >> p) & 1) == 0) p--;
		if (p >= 22) f = v >> (p - 22);
		else f = v << (22 - p);
		f = f & ((1 << 22) - 1);
		k = f >> (22 - LTB);
		r = f & ((1 << (22 - LTB)) - 1);
		t0 = log_q16(k);
		t1 = log_q16(k + 1);
		lg = t0 + (((t1 - t0) * r) >>> (22 - LTB));
		lg += (longint'(p) - (SB - 1)) * 65536;
		db = mul_rnd(lg, 394566, 24);
		return db < -25600 ? -25600 : db;
	endfunction

	function automatic longint scale_sample(longint s, longint n, longint m);
		longint mag, sh, lim;
		mag = (s < 0 ? -s : s) * m;
		sh = 16 - n;
		lim = (longint'(1) << (SB - 1)) - (s < 0 ? 0 : 1);
		if (sh > 0) mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
		else mag = mag << (-sh);
		if (mag > lim) mag = lim;
		return s < 0 ? -mag : mag;
	endfunction

	function automatic frame_t predict_frame(logic [23:0] sl, logic [23:0] sr,
			logic [15:0] sdb, bit present);
		frame_t o;
		longint l, r, ml, mr, pk, rl, crest, env_db, thr, gr, e, ep, n, f, k, rr, m;
		l = longint'($signed(sl));
		r = longint'($signed(sr));
		o.transient = p_fast;
		if (!p_enabled) begin
			o.left = sl;
			o.right = sr;
			o.gain_db = '0;
			return o;
		end
		ml = l < 0 ? -l : l;
		mr = r < 0 ? -r : r;
		pk = ml > mr ? ml : mr;
		if (pk > 8388607) pk = 8388607;
		if (pk > p_env) p_env = track(p_env, pk, p_attack);
		else p_env = track(p_env, pk, p_fast ? p_transient : p_sustain);
		p_peak = track(p_peak, pk, 273);
		p_rms = track(p_rms, pk, 27);
		rl = p_rms > 8 ? p_rms : 8;
		crest = level_db(p_peak) - level_db(rl);
		p_crest = p_crest + mul_rnd(crest - p_crest, 14, 16);
		if (!p_fast && p_crest > 1536) p_fast = 1;
		else if (p_fast && p_crest < 768) p_fast = 0;
		env_db = level_db(p_env);
		if (present) begin
			thr = longint'($signed(sdb)) + p_scene;
			if (thr > -256) thr = -256;
		end else begin
			thr = p_thr;
		end
		gr = 0;
		if (env_db > thr) gr = mul_rnd(env_db - thr, p_slope, 16);
		gr += p_makeup;
		if (gr > 32767) gr = 32767;
		if (gr < -32768) gr = -32768;
		e = mul_rnd(gr, 2786619, 16);
		ep = e + (longint'(32) << 16);
		n = (ep >>> 16) - 32;
		f = ep & 16'hFFFF;
		k = f >> 12;
		rr = f & 4095;
		m = exp_lut[k] + (((exp_lut[k + 1] - exp_lut[k]) * rr + 2048) >>> 12);
		o.left = 24'(scale_sample(l, n, m));
		o.right = 24'(scale_sample(r, n, m));
		o.gain_db = 16'(gr);
		o.transient = p_fast;
		return o;
	endfunction

	task automatic wait_drained();
		while (frames_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, longint value);
		wait_drained();
		repeat (45) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 17'(value);
		case (idx)
			pca_pkg::REG_ENABLED:   p_enabled = value[0];
			pca_pkg::REG_THRESHOLD: p_thr = longint'($signed(16'(value)));
			pca_pkg::REG_SCENE:     p_scene = longint'($signed(16'(value)));
			pca_pkg::REG_SLOPE:     p_slope = longint'($signed(17'(value)));
			pca_pkg::REG_MAKEUP:    p_makeup = longint'($signed(16'(value)));
			pca_pkg::REG_ATTACK:    p_attack = value & 16'hFFFF;
			pca_pkg::REG_SUSTAIN:   p_sustain = value & 16'hFFFF;
			default:                p_transient = value & 16'hFFFF;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(logic [23:0] sl, logic [23:0] sr, logic [15:0] sdb, bit present);
		if (gaps_on && $urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {16'd0, sdb, sr, sl};
		s_tuser <= present;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		frames_due.push_back(predict_frame(sl, sr, sdb, present));
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random(int count, int loud);
		logic [23:0] a, b;
		for (int i = 0; i < count; i++) begin
			a = $urandom;
			b = $urandom;
			if ($urandom_range(99) >= loud) begin
				a = 24'($signed(a) >>> $urandom_range(20));
				b = 24'($signed(b) >>> $urandom_range(20));
			end
			send_frame(a, b, 16'($urandom), $urandom_range(1));
		end
	endtask

	task automatic test_directed_extremes();
		send_frame(24'h000000, 24'h000000, 16'h0000, 1'b0);
		send_frame(24'h7FFFFF, 24'h000000, 16'h0000, 1'b0);
		send_frame(24'h800000, 24'h800000, 16'h0000, 1'b0);
		send_frame(24'h000000, 24'h7FFFFF, 16'h7FFF, 1'b1);
		send_frame(24'h800000, 24'h7FFFFF, 16'h8000, 1'b1);
		send_frame(24'hFFFFFF, 24'h000001, 16'hFFFF, 1'b1);
		for (int i = 0; i < 6; i++) send_frame(24'h000010, 24'hFFFFF0, 16'h0100, 1'b0);
		// sudden bursts push the crest up into transient release
		for (int i = 0; i < 12; i++) begin
			send_frame(i % 6 == 0 ? 24'h7FFFFF : 24'h000020, 24'h000000, 16'h0000, 1'b0);
		end
	endtask

	task automatic test_pass_through();
		write_reg(pca_pkg::REG_ENABLED, 0);
		send_random(15, 50);
		write_reg(pca_pkg::REG_ENABLED, 1);
	endtask

	task automatic test_scene_threshold();
		write_reg(pca_pkg::REG_SCENE, 32767);
		send_random(15, 50);
		write_reg(pca_pkg::REG_SCENE, -32768);
		send_random(15, 50);
		write_reg(pca_pkg::REG_THRESHOLD, 0);
		write_reg(pca_pkg::REG_THRESHOLD, -32768);
		send_random(15, 50);
	endtask

	task automatic test_slope_makeup();
		write_reg(pca_pkg::REG_SLOPE, -65535);
		write_reg(pca_pkg::REG_MAKEUP, 32767);
		send_random(20, 60);
		write_reg(pca_pkg::REG_MAKEUP, -32768);
		send_random(20, 60);
		write_reg(pca_pkg::REG_SLOPE, 0);
		write_reg(pca_pkg::REG_MAKEUP, 1536);
		send_random(20, 60);
	endtask

	task automatic test_coefficients();
		write_reg(pca_pkg::REG_ATTACK, 65535);
		write_reg(pca_pkg::REG_SUSTAIN, 65535);
		write_reg(pca_pkg::REG_TRANSIENT, 1);
		write_reg(pca_pkg::REG_SLOPE, -40000);
		write_reg(pca_pkg::REG_MAKEUP, 0);
		write_reg(pca_pkg::REG_THRESHOLD, -2560);
		send_random(30, 40);
		write_reg(pca_pkg::REG_ATTACK, 1);
		write_reg(pca_pkg::REG_SUSTAIN, 1);
		write_reg(pca_pkg::REG_TRANSIENT, 65535);
		send_random(30, 40);
	endtask

	task automatic test_random_run();
		write_reg(pca_pkg::REG_ATTACK, $urandom_range(1, 65535));
		write_reg(pca_pkg::REG_SUSTAIN, $urandom_range(1, 4000));
		write_reg(pca_pkg::REG_TRANSIENT, $urandom_range(1, 4000));
		write_reg(pca_pkg::REG_SLOPE, -longint'($urandom_range(0, 65535)));
		write_reg(pca_pkg::REG_SCENE, $urandom_range(0, 8000) - 16000);
		write_reg(pca_pkg::REG_THRESHOLD, -longint'($urandom_range(0, 8000)));
		send_random(100, 30);
		wait_drained();
		send_random(80, 30);
		gaps_on = 1'b0;
		send_random(40, 30);
	endtask

	// output side: random stalls, compare against the oldest prediction
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frames_due.size() == 0) begin
				$error("output word with no prediction waiting");
				fail_count++;
			end else begin
				want = frames_due.pop_front();
				if (m_tdata[23:0] !== want.left) begin
					$error("out_left expected %h actual %h", want.left, m_tdata[23:0]);
					fail_count++;
				end
				if (m_tdata[47:24] !== want.right) begin
					$error("out_right expected %h actual %h", want.right, m_tdata[47:24]);
					fail_count++;
				end
				if (m_tdata[63:48] !== want.gain_db) begin
					$error("applied_gain_db expected %h actual %h", want.gain_db,
						m_tdata[63:48]);
					fail_count++;
				end
				if (m_tuser[0] !== want.transient) begin
					$error("transient_active expected %b actual %b", want.transient,
						m_tuser[0]);
					fail_count++;
				end
			end
		end
	end

	int stall_left;
	always @(posedge clk) begin
		if (!gaps_on) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(3) == 0) begin
			stall_left <= $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 17; i++) exp_lut[i] = longint'(pca_pkg::EXP_TAB[i]);
		fail_count = 0;
		idle_cycles = 0;
		stall_left = 0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		p_enabled = 1;
		p_thr = -4608;
		p_scene = -26624;
		p_slope = -32768;
		p_makeup = 0;
		p_attack = 655;
		p_sustain = 34;
		p_transient = 136;
		p_env = 0;
		p_peak = 0;
		p_rms = 0;
		p_crest = 0;
		p_fast = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_pass_through();
		test_scene_threshold();
		test_slope_makeup();
		test_coefficients();
		test_random_run();
		wait_drained();
		repeat (60) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
